// ===== rtl/fptw_pkg.sv =====
// Package with shared constants and types for the page table walker.
`default_nettype none
package fptw_pkg;
    localparam logic [2:0] OP_MAP       = 3'd0;
    localparam logic [2:0] OP_UNMAP     = 3'd1;
    localparam logic [2:0] OP_TRANSLATE = 3'd2;
    localparam logic [2:0] OP_RAW_WRITE = 3'd3;
    localparam logic [2:0] OP_RAW_READ  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [2:0] ST_HUGE       = 3'd3;
    localparam logic [2:0] ST_OUTSIDE    = 3'd4;

    localparam logic [63:0] ENT_PRESENT   = 64'h1;
    localparam logic [63:0] ENT_WRITABLE  = 64'h2;
    localparam logic [63:0] ENT_USER      = 64'h4;
    localparam logic [63:0] ENT_HUGE      = 64'h80;
    localparam logic [63:0] ENT_ADDR_MASK = 64'h000F_FFFF_FFFF_F000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [47:0] virt_addr;
        logic [51:0] phys_addr;
        logic [63:0] flags;
        logic [3:0]  table_page;
        logic [8:0]  table_slot;
        logic [63:0] entry_value;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [51:0] phys_result;
        logic [63:0] entry_read;
        logic        flush_page;
    } t_rsp;
endpackage
`default_nettype wire

// ===== rtl/fptw_if.sv =====
// Valid/ready channel interfaces for requests, responses and configuration.
`default_nettype none
interface fptw_req_if;
    logic            valid;
    logic            ready;
    fptw_pkg::t_req  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fptw_rsp_if;
    logic            valid;
    logic            ready;
    fptw_pkg::t_rsp  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fptw_cfg_if;
    logic        valid;
    logic        ready;
    logic [39:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/fptw_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module fptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/four_level_page_table_walker_core.sv =====
// Top level of the four-level page table walker with its sequencer.
//
// Channel   Dir  Payload
// i_req     in   opcode, virt_addr, phys_addr, flags, table_page, table_slot, entry_value
// o_rsp     out  status, phys_result, entry_read, flush_page
// i_cfg     in   pool_base_frame (40 bits)
//
// A request is taken in the idle cycle. A full walk then passes through a read and a
// check state for each of the three upper levels, the leaf read, the leaf check and a
// settle state before the response is offered; a walk that stops early is shorter. A
// map adds 512 clearing writes and one link write for each new table page. A raw read
// takes a read and a capture state, a raw write the read state only, an unknown opcode
// neither. After reset the RAM is cleared one entry per cycle, all of it, before the
// first request transfer; configuration writes are taken anyway.
// The result sits in an output register; the next request waits until it is taken.
`default_nettype none
module four_level_page_table_walker_core #(
    parameter int POOL_PAGES = 16
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    fptw_req_if.sink   i_req,
    fptw_rsp_if.source o_rsp,
    fptw_cfg_if.sink   i_cfg
);
    localparam int ENTRIES = 512;
    localparam int PW      = (POOL_PAGES > 2) ? $clog2(POOL_PAGES) : 1;
    localparam int CW      = PW + 1;
    localparam int AW      = PW + 9;
    localparam int DEPTH   = POOL_PAGES * ENTRIES;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_CLR   = 4'd4;
    localparam logic [3:0] S_LINK  = 4'd5;
    localparam logic [3:0] S_LEAFR = 4'd6;
    localparam logic [3:0] S_LEAFC = 4'd7;
    localparam logic [3:0] S_RAWR  = 4'd8;
    localparam logic [3:0] S_RAWC  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]          r_state, n_state;
    logic [39:0]         r_base;
    fptw_pkg::t_req      r_req;
    fptw_pkg::t_rsp      r_rsp, n_rsp;
    logic [1:0]          r_lvl, n_lvl;
    logic [PW-1:0]       r_cur, n_cur;
    logic [AW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_next_free, n_next_free;
    logic [AW:0]         r_clr, n_clr;
    logic [PW-1:0]       r_new_pg, n_new_pg;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [63:0]         ram_wdata, ram_rdata;

    logic [8:0]          lvl_idx;
    logic [40:0]         frame_diff;
    logic [39:0]         new_frame;

    fptw_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_DONE);
    assign o_rsp.payload = r_rsp;

    always_comb begin
        unique case (r_lvl)
            2'd0:    lvl_idx = r_req.virt_addr[47:39];
            2'd1:    lvl_idx = r_req.virt_addr[38:30];
            2'd2:    lvl_idx = r_req.virt_addr[29:21];
            default: lvl_idx = r_req.virt_addr[20:12];
        endcase
    end

    // The one shared subtractor turns an entry frame into a pool page offset.
    // It keeps the borrow, so a frame below the pool base counts as outside the pool.
    assign frame_diff = {1'b0, ram_rdata[51:12]} - {1'b0, r_base};
    assign new_frame  = r_base + 40'(r_new_pg);

    always_comb begin
        n_state     = r_state;
        n_rsp       = r_rsp;
        n_lvl       = r_lvl;
        n_cur       = r_cur;
        n_pos       = r_pos;
        n_next_free = r_next_free;
        n_clr       = r_clr;
        n_new_pg    = r_new_pg;
        ram_we      = 1'b0;
        ram_addr    = r_pos;
        ram_wdata   = '0;
        unique case (r_state)
            S_INIT: begin
                ram_we   = 1'b1;
                ram_addr = r_clr[AW-1:0];
                n_clr    = r_clr + 1'b1;
                if (r_clr == (AW+1)'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_rsp = '0;
                n_lvl = 2'd0;
                n_cur = '0;
                if (i_req.valid) begin
                    unique case (i_req.payload.opcode)
                        fptw_pkg::OP_MAP, fptw_pkg::OP_UNMAP,
                        fptw_pkg::OP_TRANSLATE: n_state = S_RD;
                        fptw_pkg::OP_RAW_WRITE, fptw_pkg::OP_RAW_READ: n_state = S_RAWR;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RD: begin
                ram_addr = {r_cur, lvl_idx};
                n_pos    = {r_cur, lvl_idx};
                n_state  = (r_lvl == 2'd3) ? S_LEAFC : S_CHK;
            end
            S_CHK: begin
                if (!ram_rdata[0]) begin
                    if (r_req.opcode != fptw_pkg::OP_MAP) begin
                        n_rsp.status = fptw_pkg::ST_NOT_MAPPED;
                        n_state      = S_DONE;
                    end else if (r_next_free >= CW'(POOL_PAGES)) begin
                        n_rsp.status = fptw_pkg::ST_EXHAUSTED;
                        n_state      = S_DONE;
                    end else begin
                        n_new_pg    = r_next_free[PW-1:0];
                        n_next_free = r_next_free + 1'b1;
                        n_clr       = '0;
                        n_state     = S_CLR;
                    end
                end else if (r_lvl != 2'd0 && ram_rdata[7]) begin
                    n_rsp.status = fptw_pkg::ST_HUGE;
                    n_state      = S_DONE;
                end else if (frame_diff >= 41'(POOL_PAGES)) begin
                    n_rsp.status = fptw_pkg::ST_OUTSIDE;
                    n_state      = S_DONE;
                end else begin
                    n_cur   = frame_diff[PW-1:0];
                    n_lvl   = r_lvl + 1'b1;
                    n_state = S_RD;
                end
            end
            S_CLR: begin
                ram_we   = 1'b1;
                ram_addr = {r_new_pg, r_clr[8:0]};
                n_clr    = r_clr + 1'b1;
                if (r_clr[8:0] == 9'(ENTRIES - 1)) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                ram_we    = 1'b1;
                ram_addr  = r_pos;
                ram_wdata = ({12'd0, new_frame, 12'd0} & fptw_pkg::ENT_ADDR_MASK)
                          | fptw_pkg::ENT_PRESENT | fptw_pkg::ENT_WRITABLE
                          | fptw_pkg::ENT_USER;
                n_cur     = r_new_pg;
                n_lvl     = r_lvl + 1'b1;
                n_state   = S_RD;
            end
            S_LEAFC: begin
                n_state = S_DONE;
                if (r_req.opcode == fptw_pkg::OP_MAP) begin
                    ram_we    = 1'b1;
                    ram_wdata = ({12'd0, r_req.phys_addr} & fptw_pkg::ENT_ADDR_MASK)
                              | r_req.flags | fptw_pkg::ENT_PRESENT;
                    n_rsp.flush_page = 1'b1;
                end else if (!ram_rdata[0]) begin
                    n_rsp.status = fptw_pkg::ST_NOT_MAPPED;
                end else if (r_req.opcode == fptw_pkg::OP_UNMAP) begin
                    ram_we           = 1'b1;
                    n_rsp.flush_page = 1'b1;
                end else begin
                    n_rsp.phys_result = {ram_rdata[51:12], r_req.virt_addr[11:0]};
                end
                n_state = S_LEAFR;
            end
            S_LEAFR: begin
                n_state = S_DONE;
            end
            S_RAWR: begin
                if (32'(r_req.table_page) >= POOL_PAGES) begin
                    n_rsp.status = fptw_pkg::ST_OUTSIDE;
                    n_state      = S_DONE;
                end else begin
                    ram_addr  = {PW'(r_req.table_page), r_req.table_slot};
                    ram_we    = (r_req.opcode == fptw_pkg::OP_RAW_WRITE);
                    ram_wdata = r_req.entry_value;
                    n_state   = (r_req.opcode == fptw_pkg::OP_RAW_WRITE) ? S_DONE : S_RAWC;
                end
            end
            S_RAWC: begin
                n_rsp.entry_read = ram_rdata;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_base      <= '0;
            r_next_free <= CW'(1);
            r_clr       <= '0;
            r_lvl       <= '0;
            r_cur       <= '0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_clr       <= n_clr;
            r_lvl       <= n_lvl;
            r_cur       <= n_cur;
            if (i_cfg.valid) begin
                r_base <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp    <= n_rsp;
        r_pos    <= n_pos;
        r_new_pg <= n_new_pg;
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.payload;
        end
    end

`ifndef SYNTH
    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= CW'(POOL_PAGES))
        else $error("allocator ran past the pool");
    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free != $past(r_next_free) |-> $past(r_state) == S_CHK)
        else $error("allocator moved outside an entry check");
    a_flush_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && r_rsp.flush_page |-> r_rsp.status == fptw_pkg::ST_OK)
        else $error("flush reported with error status");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(r_rsp))
        else $error("response changed while stalled");
`endif
endmodule
`default_nettype wire
